### hw/rtl/ppp_pkg.sv
// shared types and constants of the pinhole point projection
package ppp_pkg;

	localparam int IN_W   = 32;
	localparam int OUT_W  = 16;
	localparam int ST_W   = 2;
	localparam int REG_W  = 64;
	localparam int ENT_W  = 32;
	localparam int PROD_W = 64;
	localparam int NREGS  = 6;
	localparam int IDX_W  = 3;
	localparam int SUM_W  = 68;
	localparam int QW     = 16;
	localparam int DIV_W  = SUM_W + QW;

	localparam logic [OUT_W-1:0] SAT_POS = 16'h7FFF;
	localparam logic [OUT_W-1:0] SAT_NEG = 16'h8000;

	typedef enum logic [ST_W-1:0] {
		ST_OK   = 2'd0,
		ST_WZERO = 2'd1,
		ST_SAT  = 2'd2
	} status_t;

	typedef struct packed {
		logic [DIV_W-1:0] n;
		logic [DIV_W-1:0] d;
		logic [QW-1:0]    q;
		logic             neg;
		logic             sat;
	} lane_t;

	typedef struct packed {
		lane_t col;
		lane_t row;
		logic  wz;
	} div_item_t;

endpackage

### hw/rtl/ppp_if.sv
// valid/ready channels for points in and pixels out
interface ppp_in_if;
	logic                          valid;
	logic                          ready;
	logic signed [ppp_pkg::IN_W-1:0] point_x;
	logic signed [ppp_pkg::IN_W-1:0] point_y;
	logic signed [ppp_pkg::IN_W-1:0] point_z;
	modport source (output valid, point_x, point_y, point_z, input ready);
	modport sink (input valid, point_x, point_y, point_z, output ready);
endinterface

interface ppp_out_if;
	logic                             valid;
	logic                             ready;
	logic signed [ppp_pkg::OUT_W-1:0] pixel_col;
	logic signed [ppp_pkg::OUT_W-1:0] pixel_row;
	logic [ppp_pkg::ST_W-1:0]         status;
	modport source (output valid, pixel_col, pixel_row, status, input ready);
	modport sink (input valid, pixel_col, pixel_row, status, output ready);
endinterface

### hw/rtl/pinhole_point_projection.sv
// top level: 3x4 projection with per-coordinate pipelined divide
//  channel | dir | beat
//  pts     | in  | point_x, point_y, point_z (signed fixed point)
//  pix     | out | pixel_col, pixel_row, status
//  cfg     | in  | cfg_we, cfg_index, cfg_wdata (six 64-bit matrix registers)
// one point per cycle while the output is not stalled; the pipeline has 3 multiply/sum stages,
// 2 setup stages, 16 quotient-bit stages and the output register.
// reset clears the stage valid bits and the matrix to zero.
// a full stage holds while the one after it is full and stalled, so bubbles
// close up and the input stays ready while the output waits, until every stage is full.
module pinhole_point_projection #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ppp_pkg::IDX_W-1:0]     cfg_index,
	input  logic [ppp_pkg::REG_W-1:0]     cfg_wdata,
	ppp_in_if.sink                        pts,
	ppp_out_if.source                     pix
);

	localparam int NDIV = ppp_pkg::QW;
	localparam int NST  = 5 + NDIV + 1;

	logic [ppp_pkg::REG_W-1:0]         coef_q [ppp_pkg::NREGS];
	logic [NST-1:0]                    v_q;
	logic [NST:0]                      en;
	logic signed [ppp_pkg::SUM_W-1:0]  sum_s3 [3];
	ppp_pkg::div_item_t                dv [NDIV+1];
	logic [ppp_pkg::QW-1:0]            qc, qr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ppp_pkg::NREGS; i++) coef_q[i] <= '0;
		end else if (cfg_we && (cfg_index < ppp_pkg::IDX_W'(ppp_pkg::NREGS))) begin
			coef_q[cfg_index] <= cfg_wdata;
		end
	end

	// a stage loads when it is empty or its contents move on
	always_comb begin
		en[NST] = pix.ready;
		for (int i = NST - 1; i >= 0; i--) en[i] = !v_q[i] || en[i+1];
	end

	assign pts.ready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0]) v_q[0] <= pts.valid;
			for (int i = 1; i < NST; i++) begin
				if (en[i]) v_q[i] <= v_q[i-1];
			end
		end
	end

	ppp_rows #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_rows (
		.clk    (clk),
		.en     (en[2:0]),
		.coef   (coef_q),
		.px     (pts.point_x),
		.py     (pts.point_y),
		.pz     (pts.point_z),
		.sum_s3 (sum_s3)
	);

	ppp_prep u_prep (
		.clk     (clk),
		.en      (en[4:3]),
		.sum     (sum_s3),
		.item_s5 (dv[0])
	);

	for (genvar g = 0; g < NDIV; g++) begin : g_div
		ppp_div_stage #(.K(NDIV - 1 - g)) u_stage (
			.clk    (clk),
			.en     (en[5+g]),
			.din    (dv[g]),
			.dout_q (dv[g+1])
		);
	end

	assign qc = dv[NDIV].col.neg ? ppp_pkg::QW'(-dv[NDIV].col.q) : dv[NDIV].col.q;
	assign qr = dv[NDIV].row.neg ? ppp_pkg::QW'(-dv[NDIV].row.q) : dv[NDIV].row.q;

	always_ff @(posedge clk) begin
		if (en[NST-1]) begin
			if (dv[NDIV].wz) begin
				pix.pixel_col <= '0;
				pix.pixel_row <= '0;
				pix.status    <= ppp_pkg::ST_WZERO;
			end else begin
				pix.pixel_col <= dv[NDIV].col.sat
					? (dv[NDIV].col.neg ? ppp_pkg::SAT_NEG : ppp_pkg::SAT_POS) : qc;
				pix.pixel_row <= dv[NDIV].row.sat
					? (dv[NDIV].row.neg ? ppp_pkg::SAT_NEG : ppp_pkg::SAT_POS) : qr;
				pix.status    <= (dv[NDIV].col.sat || dv[NDIV].row.sat)
					? ppp_pkg::ST_SAT : ppp_pkg::ST_OK;
			end
		end
	end

	assign pix.valid = v_q[NST-1];

endmodule

### hw/rtl/ppp_rows.sv
// matrix times homogeneous point: products, pair sums, row sums
module ppp_rows #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input  logic                                clk,
	input  logic [2:0]                          en,
	input  logic [ppp_pkg::REG_W-1:0]           coef [ppp_pkg::NREGS],
	input  logic [ppp_pkg::IN_W-1:0]            px,
	input  logic [ppp_pkg::IN_W-1:0]            py,
	input  logic [ppp_pkg::IN_W-1:0]            pz,
	output logic signed [ppp_pkg::SUM_W-1:0]    sum_s3 [3]
);

	logic signed [ppp_pkg::ENT_W-1:0]  xs, ys, zs;
	logic signed [ppp_pkg::ENT_W-1:0]  m [3][4];
	logic signed [ppp_pkg::PROD_W-1:0] prod_s1 [3][3];
	logic signed [ppp_pkg::ENT_W-1:0]  cst_s1 [3];
	logic signed [ppp_pkg::SUM_W-1:0]  a_s2 [3];
	logic signed [ppp_pkg::SUM_W-1:0]  b_s2 [3];

	assign xs = ppp_pkg::ENT_W'($signed(px[COORD_WIDTH-1:0]));
	assign ys = ppp_pkg::ENT_W'($signed(py[COORD_WIDTH-1:0]));
	assign zs = ppp_pkg::ENT_W'($signed(pz[COORD_WIDTH-1:0]));

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			m[r][0] = $signed(coef[2*r][ppp_pkg::ENT_W-1:0]);
			m[r][1] = $signed(coef[2*r][ppp_pkg::REG_W-1:ppp_pkg::ENT_W]);
			m[r][2] = $signed(coef[2*r+1][ppp_pkg::ENT_W-1:0]);
			m[r][3] = $signed(coef[2*r+1][ppp_pkg::REG_W-1:ppp_pkg::ENT_W]);
		end
	end

	always_ff @(posedge clk) begin
		for (int r = 0; r < 3; r++) begin
			if (en[0]) begin
				prod_s1[r][0] <= m[r][0] * xs;
				prod_s1[r][1] <= m[r][1] * ys;
				prod_s1[r][2] <= m[r][2] * zs;
				cst_s1[r]     <= m[r][3];
			end
			if (en[1]) begin
				a_s2[r] <= ppp_pkg::SUM_W'(prod_s1[r][0]) + ppp_pkg::SUM_W'(prod_s1[r][1]);
				// translation column times 1.0
				b_s2[r] <= ppp_pkg::SUM_W'(prod_s1[r][2])
					+ (ppp_pkg::SUM_W'(cst_s1[r]) <<< FRAC_BITS);
			end
			if (en[2]) begin
				sum_s3[r] <= a_s2[r] + b_s2[r];
			end
		end
	end

endmodule

### hw/rtl/ppp_prep.sv
// magnitudes, quotient signs and the overflow test ahead of the divider
module ppp_prep (
	input  logic                             clk,
	input  logic [1:0]                       en,
	input  logic signed [ppp_pkg::SUM_W-1:0] sum [3],
	output ppp_pkg::div_item_t               item_s5
);

	ppp_pkg::div_item_t item_s4;
	ppp_pkg::div_item_t nxt4, nxt5;

	function automatic logic [ppp_pkg::DIV_W-1:0] mag(input logic signed [ppp_pkg::SUM_W-1:0] v);
		logic [ppp_pkg::SUM_W-1:0] a;
		a = v[ppp_pkg::SUM_W-1] ? ppp_pkg::SUM_W'(-v) : ppp_pkg::SUM_W'(v);
		return ppp_pkg::DIV_W'(a);
	endfunction

	function automatic ppp_pkg::lane_t chk(input ppp_pkg::lane_t l);
		ppp_pkg::lane_t o;
		logic [ppp_pkg::DIV_W-1:0] lim;
		o = l;
		lim = (l.d << (ppp_pkg::QW - 1)) + (l.neg ? l.d : '0);
		o.sat = (l.n >= lim);
		return o;
	endfunction

	always_comb begin
		nxt4.col.n   = mag(sum[0]);
		nxt4.row.n   = mag(sum[1]);
		nxt4.col.d   = mag(sum[2]);
		nxt4.row.d   = mag(sum[2]);
		nxt4.col.q   = '0;
		nxt4.row.q   = '0;
		nxt4.col.neg = sum[0][ppp_pkg::SUM_W-1] ^ sum[2][ppp_pkg::SUM_W-1];
		nxt4.row.neg = sum[1][ppp_pkg::SUM_W-1] ^ sum[2][ppp_pkg::SUM_W-1];
		nxt4.col.sat = 1'b0;
		nxt4.row.sat = 1'b0;
		nxt4.wz      = (sum[2] == '0);
		nxt5.col     = chk(item_s4.col);
		nxt5.row     = chk(item_s4.row);
		nxt5.wz      = item_s4.wz;
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			item_s4 <= nxt4;
		end
		if (en[1]) begin
			item_s5 <= nxt5;
		end
	end

endmodule

### hw/rtl/ppp_div_stage.sv
// one restoring quotient bit for both coordinates
module ppp_div_stage #(
	parameter int K = 15
) (
	input  logic               clk,
	input  logic               en,
	input  ppp_pkg::div_item_t din,
	output ppp_pkg::div_item_t dout_q
);

	ppp_pkg::div_item_t nxt;

	function automatic ppp_pkg::lane_t step(input ppp_pkg::lane_t l);
		ppp_pkg::lane_t o;
		logic [ppp_pkg::DIV_W-1:0] t;
		o = l;
		t = l.d << K;
		if (l.n >= t) begin
			o.n    = l.n - t;
			o.q[K] = 1'b1;
		end
		return o;
	endfunction

	always_comb begin
		nxt.col = step(din.col);
		nxt.row = step(din.row);
		nxt.wz  = din.wz;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dout_q <= nxt;
		end
	end

endmodule
